// File: rtl/vccc_pkg.sv
// Shared types, corner tables and face grading for the voxel cell crossing classifier.
// No dependencies; every other file in rtl/ imports this package.
package vccc_pkg;

    localparam int NUM_CORNERS = 8;
    localparam int NUM_EDGES   = 12;
    localparam int NUM_FACES   = 6;
    localparam int IN_LABEL_W  = 16;

    // Edge end corners, bit 0 .. bit 11 of the crossing mask
    localparam int EDGE_A [NUM_EDGES] = '{0, 1, 0, 2, 4, 5, 4, 6, 0, 1, 3, 2};
    localparam int EDGE_B [NUM_EDGES] = '{3, 2, 1, 3, 7, 6, 5, 7, 4, 5, 7, 6};

    // Face corners in ring order: left, right, back, front, bottom, top
    localparam int FACE_C [NUM_FACES][4] = '{
        '{0, 3, 7, 4}, '{1, 2, 6, 5}, '{0, 1, 5, 4},
        '{3, 2, 6, 7}, '{0, 1, 2, 3}, '{4, 5, 6, 7}
    };

    typedef enum logic [1:0] {
        FACE_NONE     = 2'd0,
        FACE_SURFACE  = 2'd1,
        FACE_JUNCTION = 2'd2
    } t_face_kind;

    typedef enum logic [1:0] {
        VTX_NONE    = 2'd0,
        VTX_SURFACE = 2'd1,
        VTX_EDGE    = 2'd2,
        VTX_CORNER  = 2'd3
    } t_vertex_kind;

    // Equality of the four ring corners a,b,c,d of one face
    typedef struct packed {
        logic ab;
        logic bc;
        logic cd;
        logic da;
        logic ac;
        logic bd;
    } t_face_eq;

    typedef struct packed {
        logic [NUM_EDGES-1:0]         edges;
        t_face_eq [NUM_FACES-1:0]     faces;
    } t_cmp;

    typedef struct packed {
        logic [NUM_EDGES-1:0]         edges;
        t_face_kind [NUM_FACES-1:0]   kinds;
    } t_grade;

    typedef struct packed {
        logic [2:0]                   junction_count;
        t_vertex_kind                 vertex_kind;
        t_face_kind [NUM_FACES-1:0]   kinds;
        logic [NUM_EDGES-1:0]         edges;
    } t_result;

    // Grade one face by its distinct labels; a two-label checkerboard is a junction
    function automatic t_face_kind grade_face(input t_face_eq eq);
        logic [2:0] distinct;
        t_face_kind kind;
        distinct = 3'd1;
        if (!eq.ab) distinct = distinct + 3'd1;
        if (!eq.ac && !eq.bc) distinct = distinct + 3'd1;
        if (!eq.da && !eq.bd && !eq.cd) distinct = distinct + 3'd1;
        case (distinct)
            3'd1: kind = FACE_NONE;
            3'd2: kind = (eq.ac && eq.bd) ? FACE_JUNCTION : FACE_SURFACE;
            default: kind = FACE_JUNCTION;
        endcase
        return kind;
    endfunction

endpackage

// File: rtl/vccc_compare.sv
// Input register and corner comparison stage of the voxel cell classifier.
// Depends on vccc_pkg for tables and the comparison struct.
module vccc_compare #(
    parameter int LABEL_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [vccc_pkg::NUM_CORNERS*vccc_pkg::IN_LABEL_W-1:0] i_labels,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output vccc_pkg::t_cmp                             o_cmp
);
    import vccc_pkg::*;

    localparam int CMP_BITS = (LABEL_BITS < IN_LABEL_W) ? LABEL_BITS : IN_LABEL_W;

    logic [NUM_CORNERS-1:0][CMP_BITS-1:0] r_lab, n_lab;
    logic                                 r_lab_v;
    t_cmp                                 r_cmp, n_cmp;
    logic                                 r_cmp_v;
    logic                                 lab_adv;
    logic                                 cmp_adv;

    // A stage loads when it is empty or its word moves on
    assign cmp_adv = !r_cmp_v || i_ready;
    assign lab_adv = !r_lab_v || cmp_adv;
    assign o_ready = lab_adv;

    // Keep only the compared low label bits
    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            n_lab[i] = i_labels[i*IN_LABEL_W +: CMP_BITS];
        end
    end

    // Compare edge ends and face rings
    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            n_cmp.edges[e] = (r_lab[EDGE_A[e]] != r_lab[EDGE_B[e]]);
        end
        for (int f = 0; f < NUM_FACES; f++) begin
            n_cmp.faces[f].ab = (r_lab[FACE_C[f][0]] == r_lab[FACE_C[f][1]]);
            n_cmp.faces[f].bc = (r_lab[FACE_C[f][1]] == r_lab[FACE_C[f][2]]);
            n_cmp.faces[f].cd = (r_lab[FACE_C[f][2]] == r_lab[FACE_C[f][3]]);
            n_cmp.faces[f].da = (r_lab[FACE_C[f][3]] == r_lab[FACE_C[f][0]]);
            n_cmp.faces[f].ac = (r_lab[FACE_C[f][0]] == r_lab[FACE_C[f][2]]);
            n_cmp.faces[f].bd = (r_lab[FACE_C[f][1]] == r_lab[FACE_C[f][3]]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lab_v <= 1'b0;
            r_cmp_v <= 1'b0;
        end else begin
            if (lab_adv) r_lab_v <= i_valid;
            if (cmp_adv) r_cmp_v <= r_lab_v;
        end
    end

    // Payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (lab_adv) r_lab <= n_lab;
        if (cmp_adv) r_cmp <= n_cmp;
    end

    assign o_valid = r_cmp_v;
    assign o_cmp   = r_cmp;

endmodule

// File: rtl/vccc_grade.sv
// Face grading stage: turns ring equalities into none, surface or junction per face.
// Depends on vccc_pkg for grade_face and the stage structs.
module vccc_grade (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vccc_pkg::t_cmp    i_cmp,
    output logic              o_valid,
    input  logic              i_ready,
    output vccc_pkg::t_grade  o_grade
);
    import vccc_pkg::*;

    t_grade r_grade, n_grade;
    logic   r_v;
    logic   adv;

    assign adv     = !r_v || i_ready;
    assign o_ready = adv;

    // Grade every face; a cell with no crossing grades all none
    always_comb begin
        n_grade.edges = i_cmp.edges;
        for (int f = 0; f < NUM_FACES; f++) begin
            if (i_cmp.edges == '0) begin
                n_grade.kinds[f] = FACE_NONE;
            end else begin
                n_grade.kinds[f] = grade_face(i_cmp.faces[f]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_grade <= n_grade;
    end

    assign o_valid = r_v;
    assign o_grade = r_grade;

endmodule

// File: rtl/vccc_tally.sv
// Junction tally and vertex kind stage; its register is the block's output register.
// Depends on vccc_pkg for the stage structs and vertex codes.
module vccc_tally (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  vccc_pkg::t_grade   i_grade,
    output logic               o_valid,
    input  logic               i_ready,
    output vccc_pkg::t_result  o_result
);
    import vccc_pkg::*;

    t_result r_res, n_res;
    logic    r_v;
    logic    adv;
    logic    any_edge;

    assign adv      = !r_v || i_ready;
    assign o_ready  = adv;
    assign any_edge = (i_grade.edges != '0);

    // Count junction faces and pick the vertex kind
    always_comb begin
        n_res.edges          = i_grade.edges;
        n_res.kinds          = i_grade.kinds;
        n_res.junction_count = 3'd0;
        for (int f = 0; f < NUM_FACES; f++) begin
            if (i_grade.kinds[f] == FACE_JUNCTION) begin
                n_res.junction_count = n_res.junction_count + 3'd1;
            end
        end
        if (!any_edge) begin
            n_res.vertex_kind = VTX_NONE;
        end else if (n_res.junction_count == 3'd0) begin
            n_res.vertex_kind = VTX_SURFACE;
        end else if (n_res.junction_count <= 3'd2) begin
            n_res.vertex_kind = VTX_EDGE;
        end else begin
            n_res.vertex_kind = VTX_CORNER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_res <= n_res;
    end

    assign o_valid  = r_v;
    assign o_result = r_res;

endmodule

// File: rtl/voxel_cell_crossing_classifier_unit.sv
// Top level of the voxel cell crossing classifier: four register stages in a row.
// Depends on vccc_pkg, vccc_compare, vccc_grade and vccc_tally.
//
//   channel | dir | word                                   | accepted when
//   s_axis  | in  | eight 16-bit corner labels, 128 bits   | s_axis_tvalid & s_axis_tready
//   m_axis  | out | crossings, face kinds, vertex, count   | m_axis_tvalid & m_axis_tready
//
// Four register stages: input register, label compare, face grade, junction tally.
// The edge that accepts a cell loads the input register; the result then passes
// through the compare and grade registers to the output register. Without a
// stall, one cell enters every cycle. A stall holds each stage's word in place;
// a bubble stage still loads, so input is taken while a result waits at the output.
// Synchronous active-low reset clears the valid bits only.
module voxel_cell_crossing_classifier_unit #(
    parameter int LABEL_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // corner_label_0 [15:0], corner_label_1 [31:16], ... corner_label_7 [127:112]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // edge_crossings [11:0], left_face_kind [13:12], right_face_kind [15:14],
    // back_face_kind [17:16], front_face_kind [19:18], bottom_face_kind [21:20],
    // top_face_kind [23:22], vertex_kind [25:24], junction_count [28:26], zero [31:29]
    output logic [31:0]  m_axis_tdata
);
    import vccc_pkg::*;

    t_cmp    cmp;
    logic    cmp_v;
    logic    cmp_rdy;
    t_grade  grade;
    logic    grade_v;
    logic    grade_rdy;
    t_result res;

    vccc_compare #(
        .LABEL_BITS (LABEL_BITS)
    ) u_compare (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_labels (s_axis_tdata),
        .o_valid  (cmp_v),
        .i_ready  (cmp_rdy),
        .o_cmp    (cmp)
    );

    vccc_grade u_grade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmp_v),
        .o_ready (cmp_rdy),
        .i_cmp   (cmp),
        .o_valid (grade_v),
        .i_ready (grade_rdy),
        .o_grade (grade)
    );

    vccc_tally u_tally (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (grade_v),
        .o_ready  (grade_rdy),
        .i_grade  (grade),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    // Pack the result word, edge crossings in the low bits
    assign m_axis_tdata = {3'b000, res};

endmodule
